/* hw/rtl/ruf_pkg.sv */
package ruf_pkg;

    localparam int BYTE_W           = 8;
    localparam int POS_W            = 7;
    localparam int DIGIT_W          = 4;
    localparam int RANGE_W          = 16;
    localparam int PROD_W           = RANGE_W + 4;
    localparam int DEF_BUFFER_BYTES = 80;
    localparam int DEF_MAX_DIGITS   = 15;
    localparam int MIN_FRAME_LEN    = 12;
    localparam int MIN_CLOSE_LEN    = 4;
    localparam int START_LEN        = 4;
    localparam int SEVEN_POS        = 7;
    localparam int RECENT_DEPTH     = 6;

    // frame delimiters
    localparam logic [BYTE_W-1:0] HDR_0      = 8'hF4;
    localparam logic [BYTE_W-1:0] HDR_1      = 8'hF3;
    localparam logic [BYTE_W-1:0] HDR_2      = 8'hF2;
    localparam logic [BYTE_W-1:0] HDR_3      = 8'hF1;
    localparam logic [BYTE_W-1:0] PER_FTR_0  = 8'hF8;
    localparam logic [BYTE_W-1:0] PER_FTR_1  = 8'hF7;
    localparam logic [BYTE_W-1:0] PER_FTR_2  = 8'hF6;
    localparam logic [BYTE_W-1:0] PER_FTR_3  = 8'hF5;
    localparam logic [BYTE_W-1:0] ACK_FTR_0  = 8'h04;
    localparam logic [BYTE_W-1:0] ACK_FTR_1  = 8'h03;
    localparam logic [BYTE_W-1:0] ACK_FTR_2  = 8'h02;
    localparam logic [BYTE_W-1:0] ACK_FTR_3  = 8'h01;
    localparam logic [BYTE_W-1:0] MARK_SEVEN = 8'hAA;
    localparam logic [BYTE_W-1:0] MARK_TAIL6 = 8'h55;
    localparam logic [BYTE_W-1:0] MARK_TAIL5 = 8'h00;
    localparam logic [BYTE_W-1:0] ASCII_CR   = 8'h0D;
    localparam logic [BYTE_W-1:0] ASCII_LF   = 8'h0A;
    localparam logic [BYTE_W-1:0] ASCII_O    = 8'h4F;
    localparam logic [BYTE_W-1:0] ASCII_N    = 8'h4E;
    localparam logic [BYTE_W-1:0] ASCII_F    = 8'h46;
    localparam logic [BYTE_W-1:0] ASCII_0    = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_9    = 8'h39;

    typedef enum logic [1:0] {
        KIND_PERIODIC = 2'd0,
        KIND_ACK      = 2'd1,
        KIND_TEXT     = 2'd2
    } frame_kind_t;

    typedef struct packed {
        logic              fire;
        logic              clear;
        logic              pos_ge1;
        logic              pos_ge2;
        logic [BYTE_W-1:0] cur;
        logic [BYTE_W-1:0] prev1;
        logic [BYTE_W-1:0] prev2;
    } scan_ctl_t;

    typedef struct packed {
        logic               presence_seen;
        logic               presence_value;
        logic               digit_found;
        logic [RANGE_W-1:0] range_acc;
    } scan_status_t;

    typedef struct packed {
        logic             close;
        frame_kind_t      kind;
        logic             ok;
        logic [POS_W-1:0] length;
    } frame_result_t;

endpackage

/* hw/rtl/ruf_in_stage.sv */
module ruf_in_stage (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [ruf_pkg::BYTE_W-1:0] byte_in,
    input  logic                      advance,
    output logic                      in_stall,
    output logic                      hold_valid,
    output logic [ruf_pkg::BYTE_W-1:0] hold_byte
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [ruf_pkg::BYTE_W-1:0] byte_reg;
    logic [ruf_pkg::BYTE_W-1:0] byte_next;

    // hold the byte while the result side is stalled
    assign in_stall = valid_reg && !advance;

    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        if (!in_stall)
        begin
            valid_next = in_valid;
            if (in_valid)
            begin
                byte_next = byte_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;

endmodule

/* hw/rtl/ruf_text_scan.sv */
module ruf_text_scan #(
    parameter int MAX_DIGITS = ruf_pkg::DEF_MAX_DIGITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ruf_pkg::scan_ctl_t    ctl,
    output ruf_pkg::scan_status_t status
);

    logic [ruf_pkg::DIGIT_W-1:0] count_reg;
    logic [ruf_pkg::DIGIT_W-1:0] count_next;
    logic [ruf_pkg::RANGE_W-1:0] acc_reg;
    logic [ruf_pkg::RANGE_W-1:0] acc_next;
    logic                        seen_reg;
    logic                        seen_next;
    logic                        value_reg;
    logic                        value_next;
    logic                        stopped_reg;
    logic                        stopped_next;

    logic                        off_hit;
    logic                        on_hit;
    logic                        is_digit;
    logic [ruf_pkg::DIGIT_W-1:0] digit;
    logic [ruf_pkg::PROD_W-1:0]  prod;
    logic [ruf_pkg::DIGIT_W-1:0] count_upd;
    logic [ruf_pkg::RANGE_W-1:0] acc_upd;
    logic                        seen_upd;
    logic                        value_upd;
    logic                        stopped_upd;

    // letters of a match must all lie inside the current frame
    assign off_hit  = ctl.pos_ge2 && ctl.cur == ruf_pkg::ASCII_F
                      && ctl.prev1 == ruf_pkg::ASCII_F && ctl.prev2 == ruf_pkg::ASCII_O;
    assign on_hit   = ctl.pos_ge1 && ctl.cur == ruf_pkg::ASCII_N
                      && ctl.prev1 == ruf_pkg::ASCII_O;
    assign is_digit = ctl.cur >= ruf_pkg::ASCII_0 && ctl.cur <= ruf_pkg::ASCII_9;
    assign digit    = ruf_pkg::DIGIT_W'(ctl.cur - ruf_pkg::ASCII_0);
    assign prod     = (ruf_pkg::PROD_W'(acc_reg) << 3) + (ruf_pkg::PROD_W'(acc_reg) << 1)
                      + ruf_pkg::PROD_W'(digit);

    always_comb
    begin
        count_upd   = count_reg;
        acc_upd     = acc_reg;
        seen_upd    = seen_reg;
        value_upd   = value_reg;
        stopped_upd = stopped_reg;
        if (!stopped_reg)
        begin
            if (off_hit)
            begin
                seen_upd    = 1'b1;
                value_upd   = 1'b0;
                stopped_upd = 1'b1;
            end
            else if (on_hit)
            begin
                seen_upd    = 1'b1;
                value_upd   = 1'b1;
                stopped_upd = 1'b1;
            end
            else if (is_digit && count_reg < ruf_pkg::DIGIT_W'(MAX_DIGITS))
            begin
                // saturate at full scale
                acc_upd   = (prod > ruf_pkg::PROD_W'({ruf_pkg::RANGE_W{1'b1}}))
                            ? {ruf_pkg::RANGE_W{1'b1}} : prod[ruf_pkg::RANGE_W-1:0];
                count_upd = count_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        acc_next     = acc_reg;
        seen_next    = seen_reg;
        value_next   = value_reg;
        stopped_next = stopped_reg;
        if (ctl.fire)
        begin
            if (ctl.clear)
            begin
                count_next   = '0;
                acc_next     = '0;
                seen_next    = 1'b0;
                value_next   = 1'b0;
                stopped_next = 1'b0;
            end
            else
            begin
                count_next   = count_upd;
                acc_next     = acc_upd;
                seen_next    = seen_upd;
                value_next   = value_upd;
                stopped_next = stopped_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            acc_reg     <= '0;
            seen_reg    <= 1'b0;
            value_reg   <= 1'b0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            acc_reg     <= acc_next;
            seen_reg    <= seen_next;
            value_reg   <= value_next;
            stopped_reg <= stopped_next;
        end
    end

    // status including the current byte, ahead of any clear
    assign status.presence_seen  = seen_upd;
    assign status.presence_value = value_upd;
    assign status.digit_found    = count_upd != '0;
    assign status.range_acc      = acc_upd;

endmodule

/* hw/rtl/ruf_frame_track.sv */
module ruf_frame_track #(
    parameter int BUFFER_BYTES = ruf_pkg::DEF_BUFFER_BYTES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fire,
    input  logic [ruf_pkg::BYTE_W-1:0] cur,
    output ruf_pkg::scan_ctl_t         scan_ctl,
    output ruf_pkg::frame_result_t     result
);

    logic [ruf_pkg::POS_W-1:0]  pos_reg;
    logic [ruf_pkg::POS_W-1:0]  pos_next;
    logic [ruf_pkg::BYTE_W-1:0] start_reg [ruf_pkg::START_LEN];
    logic [ruf_pkg::BYTE_W-1:0] start_next [ruf_pkg::START_LEN];
    logic [ruf_pkg::BYTE_W-1:0] seven_reg;
    logic [ruf_pkg::BYTE_W-1:0] seven_next;
    logic [ruf_pkg::BYTE_W-1:0] recent_reg [ruf_pkg::RECENT_DEPTH];
    logic [ruf_pkg::BYTE_W-1:0] recent_next [ruf_pkg::RECENT_DEPTH];

    logic                       drop;
    logic [ruf_pkg::POS_W-1:0]  len;
    logic                       per_ftr;
    logic                       ack_ftr;
    logic                       txt_ftr;
    logic                       long_enough;
    logic                       per_ok;
    logic                       close;

    assign drop = pos_reg >= ruf_pkg::POS_W'(BUFFER_BYTES - 1);
    assign len  = pos_reg + 1'b1;

    // the window after this byte: recent_reg[1..5] then cur
    assign per_ftr = recent_reg[3] == ruf_pkg::PER_FTR_0 && recent_reg[4] == ruf_pkg::PER_FTR_1
                     && recent_reg[5] == ruf_pkg::PER_FTR_2 && cur == ruf_pkg::PER_FTR_3;
    assign ack_ftr = recent_reg[3] == ruf_pkg::ACK_FTR_0 && recent_reg[4] == ruf_pkg::ACK_FTR_1
                     && recent_reg[5] == ruf_pkg::ACK_FTR_2 && cur == ruf_pkg::ACK_FTR_3;
    assign txt_ftr = recent_reg[5] == ruf_pkg::ASCII_CR && cur == ruf_pkg::ASCII_LF;

    assign long_enough = len >= ruf_pkg::POS_W'(ruf_pkg::MIN_FRAME_LEN);
    assign per_ok      = long_enough
                         && start_reg[0] == ruf_pkg::HDR_0 && start_reg[1] == ruf_pkg::HDR_1
                         && start_reg[2] == ruf_pkg::HDR_2 && start_reg[3] == ruf_pkg::HDR_3
                         && seven_reg == ruf_pkg::MARK_SEVEN
                         && recent_reg[1] == ruf_pkg::MARK_TAIL6
                         && recent_reg[2] == ruf_pkg::MARK_TAIL5;

    assign close = !drop && len >= ruf_pkg::POS_W'(ruf_pkg::MIN_CLOSE_LEN)
                   && (per_ftr || ack_ftr || txt_ftr);

    always_comb
    begin
        result.close  = close;
        result.length = len;
        if (per_ftr)
        begin
            result.kind = ruf_pkg::KIND_PERIODIC;
            result.ok   = per_ok;
        end
        else if (ack_ftr)
        begin
            result.kind = ruf_pkg::KIND_ACK;
            result.ok   = long_enough;
        end
        else
        begin
            result.kind = ruf_pkg::KIND_TEXT;
            result.ok   = 1'b1;
        end
    end

    assign scan_ctl.fire    = fire;
    assign scan_ctl.clear   = drop || close;
    assign scan_ctl.pos_ge1 = pos_reg >= ruf_pkg::POS_W'(1);
    assign scan_ctl.pos_ge2 = pos_reg >= ruf_pkg::POS_W'(2);
    assign scan_ctl.cur     = cur;
    assign scan_ctl.prev1   = recent_reg[5];
    assign scan_ctl.prev2   = recent_reg[4];

    always_comb
    begin
        pos_next    = pos_reg;
        start_next  = start_reg;
        seven_next  = seven_reg;
        recent_next = recent_reg;
        if (fire)
        begin
            if (drop)
            begin
                // drop the byte and the frame
                pos_next = '0;
            end
            else
            begin
                pos_next = close ? '0 : len;
                if (pos_reg < ruf_pkg::POS_W'(ruf_pkg::START_LEN))
                begin
                    start_next[pos_reg[1:0]] = cur;
                end
                if (pos_reg == ruf_pkg::POS_W'(ruf_pkg::SEVEN_POS))
                begin
                    seven_next = cur;
                end
                for (int i = 0; i < ruf_pkg::RECENT_DEPTH - 1; i++)
                begin
                    recent_next[i] = recent_reg[i + 1];
                end
                recent_next[ruf_pkg::RECENT_DEPTH - 1] = cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            seven_reg <= '0;
            for (int i = 0; i < ruf_pkg::START_LEN; i++)
            begin
                start_reg[i] <= '0;
            end
            for (int i = 0; i < ruf_pkg::RECENT_DEPTH; i++)
            begin
                recent_reg[i] <= '0;
            end
        end
        else
        begin
            pos_reg    <= pos_next;
            seven_reg  <= seven_next;
            start_reg  <= start_next;
            recent_reg <= recent_next;
        end
    end

endmodule

/* hw/rtl/radar_uart_frame_splitter.sv */
// Frame splitter for the serial link of a presence radar.
//
// Input channel: one received serial byte per transaction on byte_in, under
// in_valid / in_stall. Output channel: one closed frame per transaction under
// out_valid / out_stall, carrying kind, check result, length and, for text
// lines, the presence and range decoded from the line.
//
// A byte taken into the input register passes the frame tracker and text
// scanner; a frame it closes is registered for the output ports. Throughput:
// one byte per cycle unless a stalled result holds the result register, set
// by the single pass through the frame tracker and text scanner between the
// input and result registers. Bytes that close no frame produce no transaction.
//
// Reset empties the current frame and the scan state and drops any byte or
// result in flight. While the receiver stalls, the result is held steady; one
// further byte is taken into the input register if it is empty, then in_stall
// rises until the result is taken. A frame that reaches BUFFER_BYTES-1 bytes
// is dropped together with the byte that arrives next, without a result.
module radar_uart_frame_splitter #(
    parameter int BUFFER_BYTES = ruf_pkg::DEF_BUFFER_BYTES,
    parameter int MAX_DIGITS   = ruf_pkg::DEF_MAX_DIGITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [ruf_pkg::BYTE_W-1:0]  byte_in,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  frame_kind,
    output logic                        frame_ok,
    output logic [ruf_pkg::POS_W-1:0]   frame_length,
    output logic                        presence_found,
    output logic                        presence,
    output logic                        range_found,
    output logic [ruf_pkg::RANGE_W-1:0] range_value
);

    logic                       advance;
    logic                       fire;
    logic                       hold_valid;
    logic [ruf_pkg::BYTE_W-1:0] hold_byte;
    ruf_pkg::scan_ctl_t         scan_ctl;
    ruf_pkg::scan_status_t      scan_status;
    ruf_pkg::frame_result_t     result;
    logic                       is_text;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [1:0]                  kind_reg;
    logic [1:0]                  kind_next;
    logic                        ok_reg;
    logic                        ok_next;
    logic [ruf_pkg::POS_W-1:0]   length_reg;
    logic [ruf_pkg::POS_W-1:0]   length_next;
    logic                        pfound_reg;
    logic                        pfound_next;
    logic                        presence_reg;
    logic                        presence_next;
    logic                        rfound_reg;
    logic                        rfound_next;
    logic [ruf_pkg::RANGE_W-1:0] range_reg;
    logic [ruf_pkg::RANGE_W-1:0] range_next;

    // the result register is free unless it holds a stalled transaction
    assign advance = !(out_valid_reg && out_stall);
    assign fire    = hold_valid && advance;

    ruf_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .byte_in    (byte_in),
        .advance    (advance),
        .in_stall   (in_stall),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte)
    );

    ruf_frame_track #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_frame_track (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .cur      (hold_byte),
        .scan_ctl (scan_ctl),
        .result   (result)
    );

    ruf_text_scan #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_text_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (scan_ctl),
        .status (scan_status)
    );

    assign is_text = result.kind == ruf_pkg::KIND_TEXT;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        ok_next        = ok_reg;
        length_next    = length_reg;
        pfound_next    = pfound_reg;
        presence_next  = presence_reg;
        rfound_next    = rfound_reg;
        range_next     = range_reg;
        if (advance)
        begin
            // load a closed frame, or empty the register once taken
            out_valid_next = fire && result.close;
            kind_next      = result.kind;
            ok_next        = result.ok;
            length_next    = result.length;
            pfound_next    = is_text && scan_status.presence_seen;
            presence_next  = is_text && scan_status.presence_seen
                             && scan_status.presence_value;
            rfound_next    = is_text && scan_status.digit_found;
            range_next     = (is_text && scan_status.digit_found)
                             ? scan_status.range_acc : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        ok_reg       <= ok_next;
        length_reg   <= length_next;
        pfound_reg   <= pfound_next;
        presence_reg <= presence_next;
        rfound_reg   <= rfound_next;
        range_reg    <= range_next;
    end

    assign out_valid      = out_valid_reg;
    assign frame_kind     = kind_reg;
    assign frame_ok       = ok_reg;
    assign frame_length   = length_reg;
    assign presence_found = pfound_reg;
    assign presence       = presence_reg;
    assign range_found    = rfound_reg;
    assign range_value    = range_reg;

    // a closed frame always holds at least its footer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_length >= ruf_pkg::POS_W'(ruf_pkg::MIN_CLOSE_LEN))
        else $error("closed frame shorter than a footer");

    // text fields stay clear on binary frames
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_kind != ruf_pkg::KIND_TEXT
        |-> !presence_found && !presence && !range_found && range_value == '0)
        else $error("text fields set on a binary frame");

    // only a stalled result may hold back the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    // a result taken with nothing queued behind it leaves the register empty
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !hold_valid |=> !out_valid)
        else $error("result repeated after it was taken");

endmodule
